@@ rtl/cit_pkg.sv @@
// shared types and fixed widths for the circle intersection trilateration block
package cit_pkg;

  localparam int CoordW = 16;
  localparam int MagW   = 16;
  localparam int SqW    = 32;
  localparam int DistW  = 33;
  localparam int DenW   = 34;
  localparam int KMagW  = 34;
  localparam int ProdW  = 50;
  localparam int QSqW   = 67;
  localparam int WholeW = 32;

  typedef struct packed {
    logic signed [CoordW-1:0] anchor_a_x;
    logic signed [CoordW-1:0] anchor_a_y;
    logic signed [CoordW-1:0] anchor_b_x;
    logic signed [CoordW-1:0] anchor_b_y;
    logic signed [CoordW-1:0] anchor_c_x;
    logic signed [CoordW-1:0] anchor_c_y;
    logic        [CoordW-1:0] range_a;
    logic        [CoordW-1:0] range_b;
    logic        [CoordW-1:0] range_c;
  } cit_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cand_a_x;
    logic signed [CoordW-1:0] cand_a_y;
    logic signed [CoordW-1:0] cand_b_x;
    logic signed [CoordW-1:0] cand_b_y;
    logic signed [CoordW-1:0] pick_x;
    logic signed [CoordW-1:0] pick_y;
    logic                     picked_second;
    logic                     no_solution;
  } cit_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic        [SqW-1:0]    d3sq;
    logic        [MagW-1:0]   adx;
    logic        [MagW-1:0]   ady;
    logic        [DenW-1:0]   den;
    logic        [ProdW-1:0]  kdx;
    logic        [ProdW-1:0]  kdy;
    logic                     k_neg;
    logic                     dx_neg;
    logic                     dy_neg;
    logic                     dx_zero;
    logic                     no_sol;
  } cit_side_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic        [SqW-1:0]    d3sq;
  } cit_carry_t;

endpackage

@@ rtl/cit_prep.sv @@
// front stages: baseline, squares, discriminant and the along-baseline products
module cit_prep import cit_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  cit_in_t            in_data,
  output logic               out_vld,
  output logic [QSqW-1:0]    out_q,
  output cit_side_t          out_side
);

  logic [5:0]               vld_r;
  cit_in_t                  in_r;

  logic signed [MagW:0]     dx_r, dy_r;
  logic [SqW-1:0]           d1sq_r, d2sq_r;
  cit_carry_t               c2_r;

  logic [DistW-1:0]         dd_r;
  logic [MagW-1:0]          adx_r, ady_r;
  logic                     dxn_r, dyn_r;
  logic [SqW-1:0]           d1sq3_r, d2sq3_r;
  cit_carry_t               c3_r;

  logic signed [KMagW:0]    k_r;
  logic [DistW+SqW-1:0]     lhsp_r;
  logic [DistW-1:0]         dd4_r;
  logic [MagW-1:0]          adx4_r, ady4_r;
  logic                     dxn4_r, dyn4_r;
  cit_carry_t               c4_r;

  logic [2*KMagW-1:0]       ksq_r;
  logic [ProdW-1:0]         kdx_r, kdy_r;
  logic                     kneg_r;
  logic [DistW+SqW-1:0]     lhsp5_r;
  logic [DistW-1:0]         dd5_r;
  logic [MagW-1:0]          adx5_r, ady5_r;
  logic                     dxn5_r, dyn5_r;
  cit_carry_t               c5_r;

  logic [QSqW-1:0]          q_r;
  cit_side_t                side_r;

  logic signed [2*MagW+1:0] dx_sq, dy_sq;
  logic [KMagW-1:0]         kmag;
  logic [QSqW:0]            lhs_ext, ksq_ext;
  logic                     short_q;

  function automatic logic [QSqW-1:0] lhsp_r5_shift(input logic [DistW+SqW-1:0] p);
    lhsp_r5_shift = {p, 2'b00};
  endfunction

  always_comb begin
    dx_sq   = dx_r * dx_r;
    dy_sq   = dy_r * dy_r;
    kmag    = k_r[KMagW] ? KMagW'(-k_r) : k_r[KMagW-1:0];
    lhs_ext = {1'b0, lhsp_r5_shift(lhsp5_r)};
    ksq_ext = (QSqW+1)'(ksq_r);
    short_q = lhs_ext < ksq_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;

    dx_r    <= $signed({in_r.anchor_b_x[CoordW-1], in_r.anchor_b_x})
             - $signed({in_r.anchor_a_x[CoordW-1], in_r.anchor_a_x});
    dy_r    <= $signed({in_r.anchor_b_y[CoordW-1], in_r.anchor_b_y})
             - $signed({in_r.anchor_a_y[CoordW-1], in_r.anchor_a_y});
    d1sq_r  <= SqW'(in_r.range_a) * SqW'(in_r.range_a);
    d2sq_r  <= SqW'(in_r.range_b) * SqW'(in_r.range_b);
    c2_r.x1   <= in_r.anchor_a_x;
    c2_r.y1   <= in_r.anchor_a_y;
    c2_r.cx   <= in_r.anchor_c_x;
    c2_r.cy   <= in_r.anchor_c_y;
    c2_r.d3sq <= SqW'(in_r.range_c) * SqW'(in_r.range_c);

    dd_r    <= DistW'(dx_sq[SqW-1:0]) + DistW'(dy_sq[SqW-1:0]);
    adx_r   <= dx_r[MagW] ? MagW'(-dx_r) : dx_r[MagW-1:0];
    ady_r   <= dy_r[MagW] ? MagW'(-dy_r) : dy_r[MagW-1:0];
    dxn_r   <= dx_r[MagW];
    dyn_r   <= dy_r[MagW];
    d1sq3_r <= d1sq_r;
    d2sq3_r <= d2sq_r;
    c3_r    <= c2_r;

    k_r     <= $signed({3'b000, d1sq3_r}) - $signed({3'b000, d2sq3_r})
             + $signed({2'b00, dd_r});
    lhsp_r  <= (DistW+SqW)'(dd_r) * (DistW+SqW)'(d1sq3_r);
    dd4_r   <= dd_r;
    adx4_r  <= adx_r;
    ady4_r  <= ady_r;
    dxn4_r  <= dxn_r;
    dyn4_r  <= dyn_r;
    c4_r    <= c3_r;

    ksq_r   <= (2*KMagW)'(kmag) * (2*KMagW)'(kmag);
    kdx_r   <= ProdW'(kmag) * ProdW'(adx4_r);
    kdy_r   <= ProdW'(kmag) * ProdW'(ady4_r);
    kneg_r  <= k_r[KMagW];
    lhsp5_r <= lhsp_r;
    dd5_r   <= dd4_r;
    adx5_r  <= adx4_r;
    ady5_r  <= ady4_r;
    dxn5_r  <= dxn4_r;
    dyn5_r  <= dyn4_r;
    c5_r    <= c4_r;

    q_r            <= QSqW'(lhs_ext - ksq_ext);
    side_r.x1      <= c5_r.x1;
    side_r.y1      <= c5_r.y1;
    side_r.cx      <= c5_r.cx;
    side_r.cy      <= c5_r.cy;
    side_r.d3sq    <= c5_r.d3sq;
    side_r.adx     <= adx5_r;
    side_r.ady     <= ady5_r;
    side_r.den     <= {dd5_r, 1'b0};
    side_r.kdx     <= kdx_r;
    side_r.kdy     <= kdy_r;
    side_r.k_neg   <= kneg_r;
    side_r.dx_neg  <= dxn5_r;
    side_r.dy_neg  <= dyn5_r;
    side_r.dx_zero <= (adx5_r == '0);
    side_r.no_sol  <= (dd5_r == '0) || short_q;
  end

  assign out_vld  = vld_r[5];
  assign out_q    = q_r;
  assign out_side = side_r;

endmodule

@@ rtl/cit_sqrt.sv @@
// pipelined integer square root, one result bit per stage
module cit_sqrt import cit_pkg::*; #(
  parameter int RW = 50
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [2*RW-1:0] in_rad,
  input  cit_side_t       in_side,
  output logic            out_vld,
  output logic [RW-1:0]   out_root,
  output cit_side_t       out_side
);

  logic [RW:0]     vld_r;
  logic [2*RW-1:0] rad_r  [RW+1];
  logic [RW:0]     rem_r  [RW+1];
  logic [RW-1:0]   root_r [RW+1];
  cit_side_t       side_r [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rad_r[0]  <= in_rad;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    side_r[0] <= in_side;
  end

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+2:0] trial, tst;
    logic [RW:0]   rem_nxt;
    logic [RW-1:0] root_nxt;

    always_comb begin
      trial = {rem_r[s], rad_r[s][2*RW-1-2*s -: 2]};
      tst   = {1'b0, root_r[s], 2'b01};
      if (trial >= tst) begin
        rem_nxt  = (RW+1)'(trial - tst);
        root_nxt = {root_r[s][RW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[RW:0];
        root_nxt = {root_r[s][RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      rad_r[s+1]  <= rad_r[s];
      rem_r[s+1]  <= rem_nxt;
      root_r[s+1] <= root_nxt;
      side_r[s+1] <= side_r[s];
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_side = side_r[RW];

endmodule

@@ rtl/cit_perp.sv @@
// perpendicular products and divider operands
module cit_perp import cit_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int RW        = 50,
  parameter int NW        = 66
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [RW-1:0]       in_root,
  input  cit_side_t           in_side,
  output logic                out_vld,
  output logic [3:0][NW-1:0]  out_num,
  output cit_side_t           out_side
);

  logic               vld_r;
  logic [3:0][NW-1:0] num_r;
  cit_side_t          side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    num_r[0] <= NW'(in_side.kdx) << FRAC_BITS;
    num_r[1] <= NW'(in_side.kdy) << FRAC_BITS;
    num_r[2] <= NW'(in_root) * NW'(in_side.ady);
    num_r[3] <= NW'(in_root) * NW'(in_side.adx);
    side_r   <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_num  = num_r;
  assign out_side = side_r;

endmodule

@@ rtl/cit_div.sv @@
// pipelined restoring divider, four lanes sharing one denominator
module cit_div import cit_pkg::*; #(
  parameter int NW = 66,
  parameter int QW = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [3:0][NW-1:0] in_num,
  input  cit_side_t          in_side,
  output logic               out_vld,
  output logic [3:0][QW-1:0] out_q,
  output cit_side_t          out_side
);

  logic [QW:0]          vld_r;
  logic [3:0][NW-1:0]   num_r  [QW+1];
  logic [3:0][DenW-1:0] rem_r  [QW+1];
  logic [3:0][QW-1:0]   q_r    [QW+1];
  cit_side_t            side_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      rem_r[0][l] <= DenW'(in_num[l][NW-1:QW]);
    end
    num_r[0]  <= in_num;
    q_r[0]    <= '0;
    side_r[0] <= in_side;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [3:0][DenW:0]   trial;
    logic [3:0][DenW-1:0] rem_nxt;
    logic [3:0][QW-1:0]   q_nxt;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        trial[l] = {rem_r[s][l], num_r[s][l][QW-1-s]};
        if (trial[l] >= {1'b0, side_r[s].den}) begin
          rem_nxt[l] = DenW'(trial[l] - {1'b0, side_r[s].den});
          q_nxt[l]   = q_r[s][l] | (QW'(1) << (QW-1-s));
        end else begin
          rem_nxt[l] = trial[l][DenW-1:0];
          q_nxt[l]   = q_r[s][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      num_r[s+1]  <= num_r[s];
      rem_r[s+1]  <= rem_nxt;
      q_r[s+1]    <= q_nxt;
      side_r[s+1] <= side_r[s];
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_q    = q_r[QW];
  assign out_side = side_r[QW];

endmodule

@@ rtl/cit_pick.sv @@
// candidate assembly, rounding to centimetres and third-anchor selection
module cit_pick import cit_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int QW        = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [3:0][QW-1:0] in_q,
  input  cit_side_t          in_side,
  output logic               out_vld,
  output cit_out_t           out_data
);

  localparam int SW = QW + 3;
  localparam logic signed [SW-1:0] BIAS = SW'((1 << FRAC_BITS) - 1);
  localparam logic signed [SW-1:0] ZERO = '0;
  localparam logic signed [SW-1:0] SMAX = SW'(32767);
  localparam logic signed [SW-1:0] SMIN = -SW'(32768);

  logic [3:0]               vld_r;
  logic signed [SW-1:0]     ax_r, ay_r, bx_r, by_r;
  cit_carry_t               c1_r, c2_r, c3_r;
  logic                     ns1_r, ns2_r, ns3_r;
  logic signed [CoordW-1:0] cax_r, cay_r, cbx_r, cby_r;
  logic signed [CoordW-1:0] cax3_r, cay3_r, cbx3_r, cby3_r;
  logic [DistW-1:0]         sa_r, sb_r;
  cit_out_t                 out_r;

  logic signed [QW:0]       alx, aly, px, py, pxa;
  logic signed [SW-1:0]     base_x, base_y;
  logic signed [CoordW:0]   eax, eay, ebx, eby;
  logic signed [2*CoordW+1:0] sq_ax, sq_ay, sq_bx, sq_by;
  logic signed [DistW:0]    da, db;
  logic [DistW-1:0]         ea, eb;
  cit_out_t                 out_nxt;

  function automatic logic signed [CoordW-1:0] to_cm(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] w;
    t = v + (v[SW-1] ? BIAS : ZERO);
    w = t >>> FRAC_BITS;
    if (w > SMAX) begin
      to_cm = 16'sh7FFF;
    end else if (w < SMIN) begin
      to_cm = 16'sh8000;
    end else begin
      to_cm = w[CoordW-1:0];
    end
  endfunction

  always_comb begin
    alx = $signed({1'b0, in_q[0]});
    if (in_side.k_neg != in_side.dx_neg) begin
      alx = -alx;
    end
    aly = $signed({1'b0, in_q[1]});
    if (in_side.k_neg != in_side.dy_neg) begin
      aly = -aly;
    end
    px  = $signed({1'b0, in_q[2]});
    py  = $signed({1'b0, in_q[3]});
    pxa = (!in_side.dx_zero && (in_side.dx_neg == in_side.dy_neg)) ? -px : px;
    base_x = SW'($signed(in_side.x1)) <<< FRAC_BITS;
    base_y = SW'($signed(in_side.y1)) <<< FRAC_BITS;

    eax   = $signed({cax_r[CoordW-1], cax_r}) - $signed({c2_r.cx[CoordW-1], c2_r.cx});
    eay   = $signed({cay_r[CoordW-1], cay_r}) - $signed({c2_r.cy[CoordW-1], c2_r.cy});
    ebx   = $signed({cbx_r[CoordW-1], cbx_r}) - $signed({c2_r.cx[CoordW-1], c2_r.cx});
    eby   = $signed({cby_r[CoordW-1], cby_r}) - $signed({c2_r.cy[CoordW-1], c2_r.cy});
    sq_ax = eax * eax;
    sq_ay = eay * eay;
    sq_bx = ebx * ebx;
    sq_by = eby * eby;

    da = $signed({1'b0, sa_r}) - $signed({2'b00, c3_r.d3sq});
    db = $signed({1'b0, sb_r}) - $signed({2'b00, c3_r.d3sq});
    ea = da[DistW] ? DistW'(-da) : da[DistW-1:0];
    eb = db[DistW] ? DistW'(-db) : db[DistW-1:0];

    out_nxt = '0;
    if (ns3_r) begin
      out_nxt.no_solution = 1'b1;
    end else begin
      out_nxt.cand_a_x = cax3_r;
      out_nxt.cand_a_y = cay3_r;
      out_nxt.cand_b_x = cbx3_r;
      out_nxt.cand_b_y = cby3_r;
      if (ea < eb) begin
        out_nxt.pick_x = cax3_r;
        out_nxt.pick_y = cay3_r;
        out_nxt.picked_second = 1'b0;
      end else begin
        out_nxt.pick_x = cbx3_r;
        out_nxt.pick_y = cby3_r;
        out_nxt.picked_second = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= base_x + SW'(alx) + SW'(pxa);
    bx_r <= base_x + SW'(alx) - SW'(pxa);
    ay_r <= base_y + SW'(aly) + SW'(py);
    by_r <= base_y + SW'(aly) - SW'(py);
    c1_r.x1   <= in_side.x1;
    c1_r.y1   <= in_side.y1;
    c1_r.cx   <= in_side.cx;
    c1_r.cy   <= in_side.cy;
    c1_r.d3sq <= in_side.d3sq;
    ns1_r <= in_side.no_sol;

    cax_r <= to_cm(ax_r);
    cay_r <= to_cm(ay_r);
    cbx_r <= to_cm(bx_r);
    cby_r <= to_cm(by_r);
    c2_r  <= c1_r;
    ns2_r <= ns1_r;

    sa_r   <= DistW'(sq_ax[SqW-1:0]) + DistW'(sq_ay[SqW-1:0]);
    sb_r   <= DistW'(sq_bx[SqW-1:0]) + DistW'(sq_by[SqW-1:0]);
    cax3_r <= cax_r;
    cay3_r <= cay_r;
    cbx3_r <= cbx_r;
    cby3_r <= cby_r;
    c3_r   <= c2_r;
    ns3_r  <= ns2_r;

    out_r <= out_nxt;
  end

  assign out_vld  = vld_r[3];
  assign out_data = out_r;

endmodule

@@ rtl/circle_intersection_trilateration.sv @@
// top level of the two-circle intersection and third-anchor trilateration pipeline
//
//   channel   ports                    beat taken when
//   input     start, busy, in_data     start high and busy low at a rising edge
//   result    out_valid, out_data      out_valid high for one cycle
//
// one beat enters every cycle; busy stays low
// the square root and the divider each give one result bit per stage
// synchronous reset clears the valid bits only; no other state is held
// results cannot be held off, so nothing in the pipe ever waits
module circle_intersection_trilateration import cit_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cit_in_t  in_data,
  output logic     out_valid,
  output cit_out_t out_data
);

  localparam int RW = (QSqW + 1) / 2 + FRAC_BITS;
  localparam int NW = ProdW + FRAC_BITS;
  localparam int QW = WholeW + FRAC_BITS;

  logic               prep_vld, root_vld, perp_vld, div_vld;
  logic [QSqW-1:0]    prep_q;
  cit_side_t          prep_side, root_side, perp_side, div_side;
  logic [RW-1:0]      root;
  logic [3:0][NW-1:0] perp_num;
  logic [3:0][QW-1:0] div_q;

  assign busy = 1'b0;

  cit_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_data  (in_data),
    .out_vld  (prep_vld),
    .out_q    (prep_q),
    .out_side (prep_side)
  );

  cit_sqrt #(.RW(RW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (prep_vld),
    .in_rad   ({1'b0, prep_q, {(2*FRAC_BITS){1'b0}}}),
    .in_side  (prep_side),
    .out_vld  (root_vld),
    .out_root (root),
    .out_side (root_side)
  );

  cit_perp #(.FRAC_BITS(FRAC_BITS), .RW(RW), .NW(NW)) u_perp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (root_vld),
    .in_root  (root),
    .in_side  (root_side),
    .out_vld  (perp_vld),
    .out_num  (perp_num),
    .out_side (perp_side)
  );

  cit_div #(.NW(NW), .QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (perp_vld),
    .in_num   (perp_num),
    .in_side  (perp_side),
    .out_vld  (div_vld),
    .out_q    (div_q),
    .out_side (div_side)
  );

  cit_pick #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (div_vld),
    .in_q     (div_q),
    .in_side  (div_side),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  // picked point is the candidate the flag names
  a_pick_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.no_solution |->
      (out_data.picked_second ?
        (out_data.pick_x == out_data.cand_b_x && out_data.pick_y == out_data.cand_b_y) :
        (out_data.pick_x == out_data.cand_a_x && out_data.pick_y == out_data.cand_a_y)))
    else $error("pick does not match chosen candidate");

  // no solution clears every other field
  a_nosol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_solution |->
      out_data.cand_a_x == '0 && out_data.cand_a_y == '0 &&
      out_data.cand_b_x == '0 && out_data.cand_b_y == '0 &&
      out_data.pick_x == '0 && out_data.pick_y == '0 && !out_data.picked_second)
    else $error("fields not cleared with no solution");

  // equal candidates tie, and a tie goes to the second
  a_tie_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.no_solution &&
      out_data.cand_a_x == out_data.cand_b_x && out_data.cand_a_y == out_data.cand_b_y
      |-> out_data.picked_second)
    else $error("tie not resolved to second candidate");

endmodule
